@@ hdl/i2c_master_pin_sequencer_unit_defines.svh @@
// assertion macros for the i2c master pin sequencer
// no dependencies; included by the top level only
`ifndef I2C_MASTER_PIN_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_PIN_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/i2cms_pkg.sv @@
// types and constants of the i2c master pin sequencer
// no dependencies; imported by the step logic and the top level
package i2cms_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] ACK_TRIES_RESET = 8'd10;

    // sequencer step codes
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] S_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] S_ST_SDA_HI  = 5'd1;
    localparam logic [STEP_W-1:0] S_ST_SCL_HI  = 5'd2;
    localparam logic [STEP_W-1:0] S_ST_SDA_LO  = 5'd3;
    localparam logic [STEP_W-1:0] S_ST_SCL_LO  = 5'd4;
    localparam logic [STEP_W-1:0] S_ST_SDA_RET = 5'd5;
    localparam logic [STEP_W-1:0] S_PB_BIT     = 5'd6;
    localparam logic [STEP_W-1:0] S_PB_SCL_HI  = 5'd7;
    localparam logic [STEP_W-1:0] S_PB_EARLY   = 5'd8;
    localparam logic [STEP_W-1:0] S_PB_SCL_LO  = 5'd9;
    localparam logic [STEP_W-1:0] S_PB_RELEASE = 5'd10;
    localparam logic [STEP_W-1:0] S_GA_SCL_HI  = 5'd11;
    localparam logic [STEP_W-1:0] S_GA_POLL    = 5'd12;
    localparam logic [STEP_W-1:0] S_GA_LO_OK   = 5'd13;
    localparam logic [STEP_W-1:0] S_GA_LO_FAIL = 5'd14;
    localparam logic [STEP_W-1:0] S_GB_RELEASE = 5'd15;
    localparam logic [STEP_W-1:0] S_GB_SCL_HI  = 5'd16;
    localparam logic [STEP_W-1:0] S_GB_READ    = 5'd17;
    localparam logic [STEP_W-1:0] S_GB_SCL_LO  = 5'd18;
    localparam logic [STEP_W-1:0] S_AK_SDA     = 5'd19;
    localparam logic [STEP_W-1:0] S_AK_SCL_HI  = 5'd20;
    localparam logic [STEP_W-1:0] S_AK_SCL_LO  = 5'd21;
    localparam logic [STEP_W-1:0] S_AK_SDA_HI  = 5'd22;
    localparam logic [STEP_W-1:0] S_W_CLAIM    = 5'd23;
    localparam logic [STEP_W-1:0] S_SP_SCL_LO  = 5'd24;
    localparam logic [STEP_W-1:0] S_SP_SDA_LO  = 5'd25;
    localparam logic [STEP_W-1:0] S_SP_REL_SCL = 5'd26;
    localparam logic [STEP_W-1:0] S_SP_REL_SDA = 5'd27;
    localparam logic [STEP_W-1:0] S_PB_LOAD    = 5'd28;

    // sequencer state carried from one item to the next
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              scl_drv;
        logic              scl_lvl;
        logic              sda_drv;
        logic              sda_lvl;
        logic [7:0]        shift;
        logic [2:0]        bit_idx;
        logic [7:0]        bytes_done;
        logic [7:0]        len;
        logic              read_mode;
        logic [7:0]        tries_left;
    } seq_state_t;

    // one result item
    typedef struct packed {
        logic       scl_drive;
        logic       scl_level;
        logic       sda_drive;
        logic       sda_level;
        logic       busy;
        logic       byte_taken;
        logic       rdata_valid;
        logic [7:0] rdata;
        logic       done;
        logic       status;
    } seq_result_t;

endpackage

@@ hdl/i2cms_step.sv @@
// next-state and result logic for one tick of the i2c pin sequencer
// depends on i2cms_pkg
module i2cms_step
    import i2cms_pkg::*;
(
    input  seq_state_t  st_cur,
    input  logic [1:0]  cmd,
    input  logic [7:0]  address,
    input  logic [7:0]  length,
    input  logic [7:0]  wdata,
    input  logic        sda_sample,
    input  logic [7:0]  ack_tries,
    output seq_state_t  st_next,
    output seq_result_t res
);

    always_comb begin
        seq_state_t s;
        logic       taken;
        logic       rvalid;
        logic       done;
        logic       fail;
        logic [7:0] rbyte;

        s      = st_cur;
        taken  = 1'b0;
        rvalid = 1'b0;
        done   = 1'b0;
        fail   = 1'b0;
        rbyte  = 8'd0;

        // start of a transaction, ignored while busy
        if (s.step == S_IDLE && (cmd == CMD_WRITE || cmd == CMD_READ)) begin
            s.read_mode  = (cmd == CMD_READ);
            s.shift      = {address[7:1], (cmd == CMD_READ)};
            s.len        = length;
            s.bytes_done = 8'd0;
            s.bit_idx    = 3'd0;
            s.tries_left = 8'd0;
            s.step       = S_ST_SDA_HI;
        end

        // at most one pin action per tick
        unique case (s.step) inside
            S_ST_SDA_HI: begin
                s.sda_drv = 1'b1;
                s.sda_lvl = 1'b1;
                s.step    = S_ST_SCL_HI;
            end
            S_ST_SCL_HI: begin
                s.scl_drv = 1'b1;
                s.scl_lvl = 1'b1;
                s.step    = S_ST_SDA_LO;
            end
            S_ST_SDA_LO: begin
                s.sda_lvl = 1'b0;
                s.step    = S_ST_SCL_LO;
            end
            S_ST_SCL_LO: begin
                s.scl_lvl = 1'b0;
                s.step    = S_ST_SDA_RET;
            end
            S_ST_SDA_RET: begin
                s.sda_lvl = 1'b1;
                s.bit_idx = 3'd0;
                s.step    = S_PB_BIT;
            end
            S_PB_LOAD, S_PB_BIT: begin
                // fetch a fresh write byte first when loading
                if (s.step == S_PB_LOAD) begin
                    s.shift      = wdata;
                    taken        = 1'b1;
                    s.bytes_done = s.bytes_done + 8'd1;
                    s.bit_idx    = 3'd0;
                end
                s.sda_drv = 1'b1;
                s.sda_lvl = s.shift[7];
                s.shift   = {s.shift[6:0], 1'b0};
                s.step    = S_PB_SCL_HI;
            end
            S_PB_SCL_HI: begin
                s.scl_lvl = 1'b1;
                s.step    = (s.bit_idx == 3'd7 && s.sda_lvl) ? S_PB_EARLY : S_PB_SCL_LO;
            end
            S_PB_EARLY: begin
                s.sda_drv = 1'b0;
                s.step    = S_PB_SCL_LO;
            end
            S_PB_SCL_LO: begin
                s.scl_lvl = 1'b0;
                if (s.bit_idx == 3'd7) begin
                    s.bit_idx = 3'd0;
                    s.step    = S_PB_RELEASE;
                end else begin
                    s.bit_idx = s.bit_idx + 3'd1;
                    s.step    = S_PB_BIT;
                end
            end
            S_PB_RELEASE: begin
                s.sda_drv = 1'b0;
                s.step    = S_GA_SCL_HI;
            end
            S_GA_SCL_HI: begin
                s.scl_lvl    = 1'b1;
                s.tries_left = ack_tries;
                s.step       = (ack_tries == 8'd0) ? S_GA_LO_FAIL : S_GA_POLL;
            end
            S_GA_POLL: begin
                // poll sda until the slave pulls it low or tries run out
                if (!sda_sample) begin
                    s.step = S_GA_LO_OK;
                end else begin
                    s.tries_left = s.tries_left - 8'd1;
                    if (s.tries_left == 8'd0) begin
                        s.step = S_GA_LO_FAIL;
                    end
                end
            end
            S_GA_LO_FAIL: begin
                s.scl_lvl = 1'b0;
                done      = 1'b1;
                fail      = 1'b1;
                s.step    = S_IDLE;
            end
            S_GA_LO_OK: begin
                s.scl_lvl = 1'b0;
                if (s.read_mode) begin
                    s.step = (s.bytes_done < s.len) ? S_GB_RELEASE : S_SP_SCL_LO;
                end else begin
                    s.step = (s.bytes_done < s.len) ? S_PB_LOAD : S_W_CLAIM;
                end
            end
            S_GB_RELEASE: begin
                s.sda_drv = 1'b0;
                s.shift   = 8'd0;
                s.bit_idx = 3'd0;
                s.step    = S_GB_SCL_HI;
            end
            S_GB_SCL_HI: begin
                s.scl_lvl = 1'b1;
                s.step    = S_GB_READ;
            end
            S_GB_READ: begin
                s.shift = {s.shift[6:0], sda_sample};
                s.step  = S_GB_SCL_LO;
            end
            S_GB_SCL_LO: begin
                s.scl_lvl = 1'b0;
                if (s.bit_idx == 3'd7) begin
                    rvalid       = 1'b1;
                    rbyte        = s.shift;
                    s.bytes_done = s.bytes_done + 8'd1;
                    s.bit_idx    = 3'd0;
                    s.step       = S_AK_SDA;
                end else begin
                    s.bit_idx = s.bit_idx + 3'd1;
                    s.step    = S_GB_SCL_HI;
                end
            end
            S_AK_SDA: begin
                // ack all read bytes but the last, which gets nack
                s.sda_drv = 1'b1;
                s.sda_lvl = (s.bytes_done >= s.len);
                s.step    = S_AK_SCL_HI;
            end
            S_AK_SCL_HI: begin
                s.scl_lvl = 1'b1;
                s.step    = S_AK_SCL_LO;
            end
            S_AK_SCL_LO: begin
                s.scl_lvl = 1'b0;
                s.step    = (s.bytes_done < s.len) ? S_AK_SDA_HI : S_SP_SCL_LO;
            end
            S_AK_SDA_HI: begin
                s.sda_lvl = 1'b1;
                s.step    = S_GB_RELEASE;
            end
            S_W_CLAIM: begin
                s.sda_drv = 1'b1;
                s.sda_lvl = 1'b0;
                s.step    = S_SP_SCL_LO;
            end
            S_SP_SCL_LO: begin
                s.scl_lvl = 1'b0;
                s.step    = S_SP_SDA_LO;
            end
            S_SP_SDA_LO: begin
                s.sda_lvl = 1'b0;
                s.step    = S_SP_REL_SCL;
            end
            S_SP_REL_SCL: begin
                s.scl_drv = 1'b0;
                s.step    = S_SP_REL_SDA;
            end
            S_SP_REL_SDA: begin
                s.sda_drv = 1'b0;
                done      = 1'b1;
                s.step    = S_IDLE;
            end
            default: begin
                s.step = S_IDLE;
            end
        endcase

        st_next         = s;
        res.scl_drive   = s.scl_drv;
        res.scl_level   = s.scl_lvl;
        res.sda_drive   = s.sda_drv;
        res.sda_level   = s.sda_lvl;
        res.busy        = (s.step != S_IDLE);
        res.byte_taken  = taken;
        res.rdata_valid = rvalid;
        res.rdata       = rbyte;
        res.done        = done;
        res.status      = fail;
    end

endmodule

@@ hdl/i2c_master_pin_sequencer_unit.sv @@
// I2C master pin sequencer, at most one pin action per item.
//
// Channels: s_* carries one tick item (command, address, length, write byte,
// sampled sda level); m_* returns one result item per tick with the pin
// drive/level state after the action and the transaction flags. cfg_* writes
// ack_tries, the number of sda samples taken while polling for acknowledge;
// write it only while no transaction is running.
// Path: an accepted item waits in the input register; its result is registered
// in the result register, and m_valid rises, once the result stage is free.
// Throughput: one item per cycle while m_ready is high; sequencer state and
// result register update in the same cycle, so consecutive items chain directly.
// Reset (aresetn low, synchronous): sequencer idle, both pins released with
// levels low, ack_tries back to 10, both stages empty.
// Stalls: while m_ready is low the result register holds; the input register
// still takes one more item, then s_ready drops until the result is taken.
// Depends on i2cms_pkg, i2cms_step and the defines header.
`include "i2c_master_pin_sequencer_unit_defines.svh"

module i2c_master_pin_sequencer_unit
    import i2cms_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // item input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_address,
    input  logic [7:0] s_length,
    input  logic [7:0] s_wdata,
    input  logic       s_sda_sample,
    // result output
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_scl_drive,
    output logic       m_scl_level,
    output logic       m_sda_drive,
    output logic       m_sda_level,
    output logic       m_busy_res,
    output logic       m_byte_taken,
    output logic       m_rdata_valid,
    output logic [7:0] m_rdata,
    output logic       m_done_res,
    output logic       m_status,
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_wdata
);

    logic        in_vld_reg;
    logic [1:0]  cmd_reg;
    logic [7:0]  address_reg;
    logic [7:0]  length_reg;
    logic [7:0]  wdata_reg;
    logic        sda_reg;
    logic        out_vld_reg;
    seq_result_t res_reg;
    seq_result_t res_next;
    seq_state_t  st_reg;
    seq_state_t  st_next;
    logic [7:0]  ack_tries_reg;
    logic        out_free;
    logic        advance;

    // handshake control
    assign out_free  = !out_vld_reg || m_ready;
    assign advance   = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || out_free;
    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_tries_reg <= ACK_TRIES_RESET;
        end else if (cfg_valid) begin
            ack_tries_reg <= cfg_wdata;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg     <= s_cmd;
            address_reg <= s_address;
            length_reg  <= s_length;
            wdata_reg   <= s_wdata;
            sda_reg     <= s_sda_sample;
        end
    end

    // tick logic
    i2cms_step u_step (
        .st_cur     (st_reg),
        .cmd        (cmd_reg),
        .address    (address_reg),
        .length     (length_reg),
        .wdata      (wdata_reg),
        .sda_sample (sda_reg),
        .ack_tries  (ack_tries_reg),
        .st_next    (st_next),
        .res        (res_next)
    );

    // sequencer state, updated once per processed item; all zero is the idle step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_scl_drive   = res_reg.scl_drive;
    assign m_scl_level   = res_reg.scl_level;
    assign m_sda_drive   = res_reg.sda_drive;
    assign m_sda_level   = res_reg.sda_level;
    assign m_busy_res    = res_reg.busy;
    assign m_byte_taken  = res_reg.byte_taken;
    assign m_rdata_valid = res_reg.rdata_valid;
    assign m_rdata       = res_reg.rdata;
    assign m_done_res    = res_reg.done;
    assign m_status      = res_reg.status;

    // checks
    `I2CMS_ASSERT_NOW(a_done_not_busy, m_valid && m_done_res, !m_busy_res,
        "transaction reported done while still busy")
    `I2CMS_ASSERT_NOW(a_status_with_done, m_valid && m_status, m_done_res,
        "failure status without done")
    `I2CMS_ASSERT_NOW(a_take_xor_read, m_valid, !(m_byte_taken && m_rdata_valid),
        "write byte taken and read byte delivered on one tick")
    `I2CMS_ASSERT_NEXT(a_stall_holds_item, in_vld_reg && !out_free, in_vld_reg,
        "buffered item dropped while result stage stalled")

endmodule
